@@ hdl/circle_pair_separation_unit_macros.svh @@
// Assertion macros for the circle pair separation unit.
`ifndef CIRCLE_PAIR_SEPARATION_UNIT_MACROS_SVH
`define CIRCLE_PAIR_SEPARATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/cps_pkg.sv @@
// Shared widths, beat types and helpers of the circle pair separation unit.
`default_nettype none
package cps_pkg;
  localparam int COORD_W  = 24;
  localparam int SIZE_W   = 16;
  localparam int LEN_FRAC = 8;
  localparam int DIFF_W   = COORD_W + 3;           // doubled center difference
  localparam int SUM_W    = SIZE_W + 1;            // sum of diameters
  localparam int SQ_W     = 2 * DIFF_W - 2;        // square of a difference
  localparam int D2_W     = SQ_W + 1;
  localparam int S2_W     = 2 * SUM_W;
  localparam int SMALL_W  = SUM_W + 1;             // difference when overlapped
  localparam int X_W      = S2_W + 2 * LEN_FRAC;   // radicand
  localparam int ROOT_W   = X_W / 2;
  localparam int REM_W    = X_W + 1;
  localparam int SPAN_W   = SUM_W + LEN_FRAC;
  localparam int MAG_W    = SMALL_W - 1 + SPAN_W;
  localparam int DVD_W    = MAG_W + 1;
  localparam int DEN_W    = ROOT_W + 2;
  localparam int Q_W      = 18;
  localparam int REMD_W   = DEN_W + Q_W;
  localparam int SHIFT_W  = Q_W + 1;
  localparam int WIDE_W   = COORD_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_left;
    logic signed [COORD_W-1:0] first_top;
    logic        [SIZE_W-1:0]  first_size;
    logic signed [COORD_W-1:0] second_left;
    logic signed [COORD_W-1:0] second_top;
    logic        [SIZE_W-1:0]  second_size;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_new_left;
    logic signed [COORD_W-1:0] first_new_top;
    logic signed [COORD_W-1:0] second_new_left;
    logic signed [COORD_W-1:0] second_new_top;
    logic                      overlapped;
  } out_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0]       al;
    logic [COORD_W-1:0]       at;
    logic [COORD_W-1:0]       bl;
    logic [COORD_W-1:0]       bt;
    logic                     ov;
    logic                     act;
    logic signed [SMALL_W-1:0] dx;
    logic signed [SMALL_W-1:0] dy;
    logic [SUM_W-1:0]         s;
  } sq_side_t;

  typedef struct packed {
    logic [COORD_W-1:0] al;
    logic [COORD_W-1:0] at;
    logic [COORD_W-1:0] bl;
    logic [COORD_W-1:0] bt;
    logic               ov;
    logic               act;
    logic               neg_x;
    logic               neg_y;
  } dv_side_t;

  localparam logic signed [WIDE_W-1:0] COORD_MAX_W = WIDE_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] COORD_MIN_W = -WIDE_W'(1 << (COORD_W - 1));

  // Corner moved by a signed shift, clamped to the coordinate range.
  function automatic logic [COORD_W-1:0] move_sat(input logic [COORD_W-1:0] c,
                                                  input logic signed [SHIFT_W-1:0] sh,
                                                  input logic add);
    logic signed [WIDE_W-1:0] cw;
    logic signed [WIDE_W-1:0] sw;
    logic signed [WIDE_W-1:0] r;
    cw = $signed({{(WIDE_W-COORD_W){c[COORD_W-1]}}, c});
    sw = $signed({{(WIDE_W-SHIFT_W){sh[SHIFT_W-1]}}, sh});
    r  = add ? (cw + sw) : (cw - sw);
    if (r > COORD_MAX_W) begin
      move_sat = COORD_MAX_W[COORD_W-1:0];
    end else if (r < COORD_MIN_W) begin
      move_sat = COORD_MIN_W[COORD_W-1:0];
    end else begin
      move_sat = r[COORD_W-1:0];
    end
  endfunction
endpackage
`default_nettype wire

@@ hdl/cps_front.sv @@
// Front stages: center differences, squares and the overlap test.
`default_nettype none
module cps_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        v_in,
  input  wire cps_pkg::in_beat_t           beat_in,
  output logic                             v_out,
  output logic [cps_pkg::X_W-1:0]          x_out,
  output cps_pkg::sq_side_t                side_out
);
  localparam int CW = cps_pkg::COORD_W;
  localparam int DW = cps_pkg::DIFF_W;

  logic signed [DW-1:0] hx, hy, ds, dx1_nxt, dy1_nxt;
  logic [cps_pkg::SUM_W-1:0] s1_nxt;
  logic v1_r;
  logic signed [DW-1:0] dx1_r, dy1_r;
  logic [cps_pkg::SUM_W-1:0] s1_r;
  cps_pkg::in_beat_t beat1_r;

  logic signed [2*DW-1:0] pxx, pyy;
  logic v2_r;
  logic [cps_pkg::SQ_W-1:0] dxx2_r, dyy2_r;
  logic [cps_pkg::S2_W-1:0] ss2_r;
  logic signed [cps_pkg::SMALL_W-1:0] dx2_r, dy2_r;
  logic [cps_pkg::SUM_W-1:0] s2_r;
  cps_pkg::in_beat_t beat2_r;

  logic [cps_pkg::D2_W-1:0] d2;
  logic ov3;
  logic v3_r;
  logic [cps_pkg::X_W-1:0] x3_r;
  cps_pkg::sq_side_t side3_r;

  // centers kept doubled: 2*left + size
  always_comb begin
    hx = $signed({{(DW-CW){beat_in.second_left[CW-1]}}, beat_in.second_left})
       - $signed({{(DW-CW){beat_in.first_left[CW-1]}}, beat_in.first_left});
    hy = $signed({{(DW-CW){beat_in.second_top[CW-1]}}, beat_in.second_top})
       - $signed({{(DW-CW){beat_in.first_top[CW-1]}}, beat_in.first_top});
    ds = $signed({{(DW-cps_pkg::SIZE_W){1'b0}}, beat_in.second_size})
       - $signed({{(DW-cps_pkg::SIZE_W){1'b0}}, beat_in.first_size});
    dx1_nxt = (hx <<< 1) + ds;
    dy1_nxt = (hy <<< 1) + ds;
    s1_nxt  = {1'b0, beat_in.first_size} + {1'b0, beat_in.second_size};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    pxx = dx1_r * dx1_r;
    pyy = dy1_r * dy1_r;
  end

  always_comb begin
    d2  = {1'b0, dxx2_r} + {1'b0, dyy2_r};
    ov3 = d2 < {{(cps_pkg::D2_W-cps_pkg::S2_W){1'b0}}, ss2_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r   <= dx1_nxt;
      dy1_r   <= dy1_nxt;
      s1_r    <= s1_nxt;
      beat1_r <= beat_in;

      dxx2_r  <= pxx[cps_pkg::SQ_W-1:0];
      dyy2_r  <= pyy[cps_pkg::SQ_W-1:0];
      ss2_r   <= s1_r * s1_r;
      dx2_r   <= dx1_r[cps_pkg::SMALL_W-1:0];
      dy2_r   <= dy1_r[cps_pkg::SMALL_W-1:0];
      s2_r    <= s1_r;
      beat2_r <= beat1_r;

      // only read when overlapped, where d2 fits the low bits
      x3_r        <= {d2[cps_pkg::S2_W-1:0], {(2*cps_pkg::LEN_FRAC){1'b0}}};
      side3_r.al  <= beat2_r.first_left;
      side3_r.at  <= beat2_r.first_top;
      side3_r.bl  <= beat2_r.second_left;
      side3_r.bt  <= beat2_r.second_top;
      side3_r.ov  <= ov3;
      side3_r.act <= ov3 && (d2 != '0);
      side3_r.dx  <= dx2_r;
      side3_r.dy  <= dy2_r;
      side3_r.s   <= s2_r;
    end
  end

  assign v_out    = v3_r;
  assign x_out    = x3_r;
  assign side_out = side3_r;
endmodule
`default_nettype wire

@@ hdl/cps_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module cps_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        v_in,
  input  wire logic [cps_pkg::X_W-1:0]     x_in,
  input  wire cps_pkg::sq_side_t           side_in,
  output logic                             v_out,
  output logic [cps_pkg::ROOT_W-1:0]       root_out,
  output cps_pkg::sq_side_t                side_out
);
  localparam int RW = cps_pkg::ROOT_W;
  localparam int MW = cps_pkg::REM_W;

  logic              v_r    [RW];
  logic [RW-1:0]     root_r [RW];
  logic [MW-1:0]     rem_r  [RW-1];
  cps_pkg::sq_side_t side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    localparam int B = RW - 1 - k;
    logic [MW-1:0]     rem_i, cand;
    logic [RW-1:0]     root_i;
    logic              v_i, take;
    cps_pkg::sq_side_t side_i;

    if (k == 0) begin : g_first
      assign rem_i  = {1'b0, x_in};
      assign root_i = '0;
      assign v_i    = v_in;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign v_i    = v_r[k-1];
      assign side_i = side_r[k-1];
    end

    // (r + 2^B)^2 - r^2
    assign cand = (MW'(root_i) << (B + 1)) + (MW'(1) << (2 * B));
    assign take = rem_i >= cand;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= take ? (root_i | (RW'(1) << B)) : root_i;
        side_r[k] <= side_i;
      end
    end

    if (k < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? (rem_i - cand) : rem_i;
        end
      end
    end
  end

  assign v_out    = v_r[RW-1];
  assign root_out = root_r[RW-1];
  assign side_out = side_r[RW-1];
endmodule
`default_nettype wire

@@ hdl/cps_div.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module cps_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        v_in,
  input  wire logic [cps_pkg::DVD_W-1:0]   dvd_x,
  input  wire logic [cps_pkg::DVD_W-1:0]   dvd_y,
  input  wire logic [cps_pkg::DEN_W-1:0]   den,
  input  wire cps_pkg::dv_side_t           side_in,
  output logic                             v_out,
  output logic [cps_pkg::Q_W-1:0]          q_x,
  output logic [cps_pkg::Q_W-1:0]          q_y,
  output cps_pkg::dv_side_t                side_out
);
  localparam int QW = cps_pkg::Q_W;
  localparam int MW = cps_pkg::REMD_W;
  localparam int NW = cps_pkg::DEN_W;

  logic              v_r     [QW];
  logic [QW-1:0]     qx_r    [QW];
  logic [QW-1:0]     qy_r    [QW];
  logic [MW-1:0]     remx_r  [QW-1];
  logic [MW-1:0]     remy_r  [QW-1];
  logic [NW-1:0]     den_r   [QW-1];
  cps_pkg::dv_side_t side_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    localparam int B = QW - 1 - k;
    logic [MW-1:0]     rx_i, ry_i, trial;
    logic [QW-1:0]     qx_i, qy_i;
    logic [NW-1:0]     den_i;
    logic              v_i, tx, ty;
    cps_pkg::dv_side_t side_i;

    if (k == 0) begin : g_first
      assign rx_i   = MW'(dvd_x);
      assign ry_i   = MW'(dvd_y);
      assign qx_i   = '0;
      assign qy_i   = '0;
      assign den_i  = den;
      assign v_i    = v_in;
      assign side_i = side_in;
    end else begin : g_next
      assign rx_i   = remx_r[k-1];
      assign ry_i   = remy_r[k-1];
      assign qx_i   = qx_r[k-1];
      assign qy_i   = qy_r[k-1];
      assign den_i  = den_r[k-1];
      assign v_i    = v_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign trial = MW'(den_i) << B;
    assign tx    = rx_i >= trial;
    assign ty    = ry_i >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qx_r[k]   <= tx ? (qx_i | (QW'(1) << B)) : qx_i;
        qy_r[k]   <= ty ? (qy_i | (QW'(1) << B)) : qy_i;
        side_r[k] <= side_i;
      end
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          remx_r[k] <= tx ? (rx_i - trial) : rx_i;
          remy_r[k] <= ty ? (ry_i - trial) : ry_i;
          den_r[k]  <= den_i;
        end
      end
    end
  end

  assign v_out    = v_r[QW-1];
  assign q_x      = qx_r[QW-1];
  assign q_y      = qy_r[QW-1];
  assign side_out = side_r[QW-1];
endmodule
`default_nettype wire

@@ hdl/circle_pair_separation_unit.sv @@
// Pipeline from input beat to output beat: 3 front, 25 root, 3 scale and 18 divide
// stages, then 1 output register; a stalled output can hold a beat back further.
// Throughput: one pair per cycle; the pipeline stops only when the output skid
// register is full, set by the output being stalled.
// Reset: rst_n synchronous, clears all valid bits, including those of the output/skid slots.
`default_nettype none
`include "circle_pair_separation_unit_macros.svh"
module circle_pair_separation_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire cps_pkg::in_beat_t   in_beat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cps_pkg::out_beat_t       out_beat
);
  localparam int SW = cps_pkg::SMALL_W;

  logic en;
  logic fr_v, sq_v, dv_v;
  logic [cps_pkg::X_W-1:0] fr_x;
  cps_pkg::sq_side_t fr_side, sq_side;
  logic [cps_pkg::ROOT_W-1:0] sq_root;

  logic v1_r, v2_r, v3_r;
  logic [cps_pkg::SPAN_W-1:0] span1_r;
  logic [cps_pkg::ROOT_W-1:0] lq1_r, lq2_r;
  logic [SW-2:0] ax1_r, ay1_r;
  logic signed [SW-1:0] ax_w, ay_w;
  cps_pkg::dv_side_t side1_r, side2_r, side3_r;
  logic [cps_pkg::MAG_W-1:0] magx2_r, magy2_r;
  logic [cps_pkg::DVD_W-1:0] dvdx3_r, dvdy3_r;
  logic [cps_pkg::DEN_W-1:0] den3_r;

  logic [cps_pkg::Q_W-1:0] qx, qy;
  cps_pkg::dv_side_t dv_side;
  logic signed [cps_pkg::SHIFT_W-1:0] sx, sy;
  cps_pkg::out_beat_t fin_beat;

  logic out_valid_r, skid_valid_r;
  cps_pkg::out_beat_t out_beat_r, skid_beat_r;
  logic out_free;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  cps_front u_front (
    .clk, .rst_n, .en,
    .v_in     (in_valid),
    .beat_in  (in_beat),
    .v_out    (fr_v),
    .x_out    (fr_x),
    .side_out (fr_side)
  );

  cps_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .v_in     (fr_v),
    .x_in     (fr_x),
    .side_in  (fr_side),
    .v_out    (sq_v),
    .root_out (sq_root),
    .side_out (sq_side)
  );

  // scale stages: span = S*2^LEN_FRAC - Lq, |d|*span, then round bias and 4*Lq
  always_comb begin
    ax_w = sq_side.dx[SW-1] ? -sq_side.dx : sq_side.dx;
    ay_w = sq_side.dy[SW-1] ? -sq_side.dy : sq_side.dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= sq_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      span1_r       <= {sq_side.s, {cps_pkg::LEN_FRAC{1'b0}}} - cps_pkg::SPAN_W'(sq_root);
      lq1_r         <= sq_root;
      ax1_r         <= ax_w[SW-2:0];
      ay1_r         <= ay_w[SW-2:0];
      side1_r.al    <= sq_side.al;
      side1_r.at    <= sq_side.at;
      side1_r.bl    <= sq_side.bl;
      side1_r.bt    <= sq_side.bt;
      side1_r.ov    <= sq_side.ov;
      side1_r.act   <= sq_side.act;
      side1_r.neg_x <= sq_side.dx[SW-1];
      side1_r.neg_y <= sq_side.dy[SW-1];

      magx2_r <= ax1_r * span1_r;
      magy2_r <= ay1_r * span1_r;
      lq2_r   <= lq1_r;
      side2_r <= side1_r;

      dvdx3_r <= {1'b0, magx2_r} + cps_pkg::DVD_W'({lq2_r, 1'b0});
      dvdy3_r <= {1'b0, magy2_r} + cps_pkg::DVD_W'({lq2_r, 1'b0});
      den3_r  <= {lq2_r, 2'b00};
      side3_r <= side2_r;
    end
  end

  cps_div u_div (
    .clk, .rst_n, .en,
    .v_in     (v3_r),
    .dvd_x    (dvdx3_r),
    .dvd_y    (dvdy3_r),
    .den      (den3_r),
    .side_in  (side3_r),
    .v_out    (dv_v),
    .q_x      (qx),
    .q_y      (qy),
    .side_out (dv_side)
  );

  always_comb begin
    sx = '0;
    sy = '0;
    if (dv_side.act) begin
      sx = dv_side.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      sy = dv_side.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end
    fin_beat.first_new_left  = cps_pkg::move_sat(dv_side.al, sx, 1'b0);
    fin_beat.first_new_top   = cps_pkg::move_sat(dv_side.at, sy, 1'b0);
    fin_beat.second_new_left = cps_pkg::move_sat(dv_side.bl, sx, 1'b1);
    fin_beat.second_new_top  = cps_pkg::move_sat(dv_side.bt, sy, 1'b1);
    fin_beat.overlapped      = dv_side.ov;
  end

  // output register plus skid slot
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || (en && dv_v);
      skid_valid_r <= 1'b0;
    end else if (en && dv_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_beat_r <= skid_valid_r ? skid_beat_r : fin_beat;
    end else if (en && dv_v) begin
      skid_beat_r <= fin_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `CPS_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_r, out_valid_r)
  `CPS_ASSERT_NEXT(a_skid_only_on_hold, clk, rst_n, !skid_valid_r && !(out_valid_r && out_stall), !skid_valid_r)
  `CPS_ASSERT_IMP(a_act_implies_ov, clk, rst_n, dv_v && dv_side.act, dv_side.ov)
endmodule
`default_nettype wire
